/* rtl/i2a_pkg.sv */
// Shared types, constants and helpers for the integer to radix ASCII unit.
// No dependencies; every other file in rtl except i2a_ram imports this package.
package i2a_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int IN_BITS     = 64;
	localparam int MAX_DIGITS  = VALUE_WIDTH;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W      = $clog2(MAX_DIGITS);

	localparam int RADIX_BITS  = 6;
	localparam int CHAR_BITS   = 8;
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
	localparam logic [CHAR_BITS-1:0]  LETTER_RESET = 8'd97;
	localparam logic [CHAR_BITS-1:0]  DEC_BASE    = 8'd10;
	localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0]  ASCII_MINUS = 8'h2d;

	localparam logic [1:0] REG_RADIX       = 2'd0;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
	localparam logic [1:0] REG_LETTER_BASE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAD,
		ST_DIV,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [RADIX_BITS-1:0] radix;
		logic                  signed_mode;
		logic [CHAR_BITS-1:0]  letter_base;
	} cfg_t;

	typedef struct packed {
		logic                  done;
		logic                  quo_nz;
		logic [RADIX_BITS-1:0] rem;
	} div_stat_t;

	function automatic logic [CHAR_BITS-1:0] digit_to_ascii(
		input logic [RADIX_BITS-1:0] d,
		input logic [CHAR_BITS-1:0]  lb
	);
		logic [CHAR_BITS-1:0] d8;
		d8 = {{(CHAR_BITS-RADIX_BITS){1'b0}}, d};
		if (d8 < DEC_BASE) begin
			return d8 + ASCII_ZERO;
		end
		return lb + d8 - DEC_BASE;
	endfunction

endpackage

/* rtl/i2a_in_if.sv */
// Input channel of the conversion unit: one raw value per transfer.
// Depends on i2a_pkg.
interface i2a_in_if import i2a_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IN_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

/* rtl/i2a_out_if.sv */
// Output channel of the conversion unit: one ASCII digit and its flags per transfer.
// Depends on i2a_pkg.
interface i2a_out_if import i2a_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] digit_char;
	logic                 negative;
	logic                 bad_radix;
	logic                 last;

	modport source(output valid, output digit_char, output negative, output bad_radix,
		output last, input ready);
	modport sink(input valid, input digit_char, input negative, input bad_radix,
		input last, output ready);
endinterface

/* rtl/i2a_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module i2a_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/i2a_cfg_regs.sv */
// APB-style configuration registers: radix, signed mode and letter base.
// Depends on i2a_pkg.
module i2a_cfg_regs import i2a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix       <= RADIX_RESET;
			cfg_q.signed_mode <= 1'b1;
			cfg_q.letter_base <= LETTER_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX:       cfg_q.radix       <= pwdata[RADIX_BITS-1:0];
				REG_SIGNED_MODE: cfg_q.signed_mode <= pwdata[0];
				REG_LETTER_BASE: cfg_q.letter_base <= pwdata[CHAR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RADIX:       prdata = {{(CFG_DATA_W-RADIX_BITS){1'b0}}, cfg_q.radix};
			REG_SIGNED_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.signed_mode};
			REG_LETTER_BASE: prdata = {{(CFG_DATA_W-CHAR_BITS){1'b0}}, cfg_q.letter_base};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/i2a_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, remainder in a narrow register.
// Depends on i2a_pkg.
module i2a_divider import i2a_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [VALUE_WIDTH-1:0] load_value,
	input  logic                   cont,
	input  logic [RADIX_BITS-1:0]  radix,
	output div_stat_t              stat
);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [RADIX_BITS-1:0]  rem_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic                   nz_q;

	logic [RADIX_BITS:0]    trial;
	logic [RADIX_BITS:0]    diff;
	logic                   ge;
	logic                   last_bit;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign trial    = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge       = trial >= {1'b0, radix};
	assign diff     = trial - {1'b0, radix};
	assign last_bit = bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			done_q    <= 1'b0;
			nz_q      <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= run_q && last_bit;
			if (load || cont) begin
				run_q     <= 1'b1;
				nz_q      <= 1'b0;
				bit_cnt_q <= '0;
			end else if (run_q) begin
				nz_q      <= nz_q | ge;
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				if (last_bit) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= load_value;
			rem_q <= '0;
		end else if (cont) begin
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
		end
	end

	assign stat.done   = done_q;
	assign stat.quo_nz = nz_q;
	assign stat.rem    = rem_q;

endmodule

/* rtl/int64_to_radix_ascii_unit.sv */
// Top level of the integer to radix ASCII unit: sequencer, digit store and output register.
// Depends on i2a_pkg, i2a_in_if, i2a_out_if, i2a_ram, i2a_cfg_regs and i2a_divider.
//
// Converts one 64-bit value per input transfer into ASCII digits in the configured radix
// (2 to 36), most significant digit first, one digit per output transfer; last marks the
// final digit and negative is set on every digit of a value that was negative in signed
// mode. An out-of-range radix gives a single transfer with bad_radix and last set. Digits
// are produced least significant first by a bit-serial divider that retires one quotient
// bit per cycle, and are parked in a 64-entry digit RAM; readout then alternates a read
// state and an emit state per digit through the registered RAM port. The next value is
// accepted as soon as the last digit sits in the output register.
module int64_to_radix_ascii_unit import i2a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	i2a_in_if.sink                in_ch,
	i2a_out_if.source             out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t                    cfg;
	div_stat_t               div_stat;
	state_t                  state_q, state_d;

	logic [VALUE_WIDTH-1:0]  in_val;
	logic [VALUE_WIDTH-1:0]  in_mag;
	logic                    in_neg;
	logic                    radix_bad;
	logic                    slot_free;
	logic                    more_digits;

	logic                    div_load, div_cont, ram_we, ram_re, out_load;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic [RADIX_BITS-1:0]   ram_rdata;
	logic [ADDR_W-1:0]       ram_raddr;

	logic                    out_valid_q;
	logic [CHAR_BITS-1:0]    out_char_q;
	logic                    out_neg_q;
	logic                    out_bad_q;
	logic                    out_last_q;

	i2a_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_val    = in_ch.value[VALUE_WIDTH-1:0];
	assign in_neg    = cfg.signed_mode && in_val[VALUE_WIDTH-1];
	assign in_mag    = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
	assign radix_bad = (cfg.radix < RADIX_MIN) || (cfg.radix > RADIX_MAX);

	i2a_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (div_load),
		.load_value (in_mag),
		.cont       (div_cont),
		.radix      (cfg.radix),
		.stat       (div_stat)
	);

	assign ram_raddr = ADDR_W'(cnt_q - CNT_W'(1));

	i2a_ram #(
		.WIDTH (RADIX_BITS),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (div_stat.rem),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free   = !out_valid_q || out_ch.ready;
	assign more_digits = div_stat.quo_nz && ((cnt_q + CNT_W'(1)) < CNT_W'(MAX_DIGITS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = radix_bad ? ST_BAD : ST_DIV;
				end
			end
			ST_BAD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_stat.done && !more_digits) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		div_load    = 1'b0;
		div_cont    = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				div_load    = in_ch.valid && !radix_bad;
			end
			ST_BAD: begin
				out_load = slot_free;
			end
			ST_DIV: begin
				ram_we   = div_stat.done;
				div_cont = div_stat.done && more_digits;
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			ST_EMIT: begin
				out_load = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Count up while storing digits, then count down while emitting them.
			if (div_load) begin
				cnt_q <= '0;
			end else if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (out_load && state_q == ST_EMIT) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			neg_q <= in_neg;
		end
		if (out_load) begin
			if (state_q == ST_BAD) begin
				out_char_q <= '0;
				out_neg_q  <= 1'b0;
				out_bad_q  <= 1'b1;
				out_last_q <= 1'b1;
			end else begin
				out_char_q <= digit_to_ascii(ram_rdata, cfg.letter_base);
				out_neg_q  <= neg_q;
				out_bad_q  <= 1'b0;
				out_last_q <= cnt_q == CNT_W'(1);
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.digit_char = out_char_q;
	assign out_ch.negative   = out_neg_q;
	assign out_ch.bad_radix  = out_bad_q;
	assign out_ch.last       = out_last_q;

	a_we_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_DIV)
		else $error("digit RAM written outside the divide phase");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count past the store depth");

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_last_q)
		else $error("bad radix result without last");

	a_emit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_EMIT) |-> cnt_q != '0)
		else $error("readout with an empty digit store");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

endmodule

/* verif/i2a_digit_checker.sv */
// Scoreboard for the integer to radix ASCII unit: tracks the format registers from the
// APB writes, predicts the digit stream of every accepted value and checks each output.
// Depends on i2a_pkg, i2a_in_if and i2a_out_if.
module i2a_digit_checker import i2a_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	i2a_in_if                     in_ch,
	i2a_out_if                    out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output int                    pending,
	output int                    errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAR_BITS-1:0] digit_char;
		logic                 negative;
		logic                 bad_radix;
		logic                 last;
	} digit_res_t;

	cfg_t       fmt;
	digit_res_t digit_q[$];
	int         fail_cnt;

	// Queue the characters of one value, most significant digit first.
	function automatic void predict_digits(input logic [IN_BITS-1:0] raw);
		logic [VALUE_WIDTH-1:0] mag;
		logic [RADIX_BITS-1:0]  digs[MAX_DIGITS];
		logic                   neg;
		logic [CHAR_BITS-1:0]   code;
		int                     n;
		int                     k;
		digit_res_t             res;
		if (fmt.radix < RADIX_MIN || fmt.radix > RADIX_MAX) begin
			res = '{digit_char: '0, negative: 1'b0, bad_radix: 1'b1, last: 1'b1};
			digit_q.push_back(res);
			return;
		end
		mag = raw[VALUE_WIDTH-1:0];
		neg = fmt.signed_mode && mag[VALUE_WIDTH-1];
		if (neg) begin
			mag = -mag;
		end
		n = 0;
		do begin
			digs[n] = RADIX_BITS'(mag % VALUE_WIDTH'(fmt.radix));
			mag = mag / VALUE_WIDTH'(fmt.radix);
			n++;
		end while (mag != 0 && n < MAX_DIGITS);
		for (k = n - 1; k >= 0; k--) begin
			// letter codes wrap past 255 by the 8-bit arithmetic
			if (digs[k] < RADIX_BITS'(DEC_BASE)) begin
				code = ASCII_ZERO + CHAR_BITS'(digs[k]);
			end else begin
				code = fmt.letter_base + CHAR_BITS'(digs[k]) - DEC_BASE;
			end
			res = '{digit_char: code, negative: neg, bad_radix: 1'b0, last: (k == 0)};
			digit_q.push_back(res);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digit_res_t want;
		if (!arst_n) begin
			fmt <= '{radix: RADIX_RESET, signed_mode: 1'b1, letter_base: LETTER_RESET};
			digit_q.delete();
			fail_cnt = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_W-1:2])
					REG_RADIX:       fmt.radix <= pwdata[RADIX_BITS-1:0];
					REG_SIGNED_MODE: fmt.signed_mode <= pwdata[0];
					REG_LETTER_BASE: fmt.letter_base <= pwdata[CHAR_BITS-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_digits(in_ch.value);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (digit_q.size() == 0) begin
					$error("unexpected digit transfer: digit_char %0h", out_ch.digit_char);
					fail_cnt++;
				end else begin
					want = digit_q.pop_front();
					if (out_ch.digit_char !== want.digit_char) begin
						$error("digit_char: expected %0h, got %0h", want.digit_char,
							out_ch.digit_char);
						fail_cnt++;
					end
					if (out_ch.negative !== want.negative) begin
						$error("negative: expected %0b, got %0b", want.negative,
							out_ch.negative);
						fail_cnt++;
					end
					if (out_ch.bad_radix !== want.bad_radix) begin
						$error("bad_radix: expected %0b, got %0b", want.bad_radix,
							out_ch.bad_radix);
						fail_cnt++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, out_ch.last);
						fail_cnt++;
					end
				end
			end
			pending <= digit_q.size();
			errors <= fail_cnt;
		end
	end

endmodule

/* verif/int64_to_radix_ascii_unit_tb.sv */
// Testbench top for the integer to radix ASCII unit: clock, reset, APB format writes,
// value stimulus and output back-pressure; checking is done by i2a_digit_checker.
// Depends on i2a_pkg, i2a_in_if, i2a_out_if, i2a_digit_checker and the unit itself.
module int64_to_radix_ascii_unit_tb import i2a_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_UNUSED    = 2'd3;
	localparam int         HOLD_CYCLES   = 2000;
	localparam int         QUIET_LIMIT   = 20000;
	localparam int         SETTLE_CYCLES = 200;
	localparam logic [IN_BITS-1:0] ALL_ONES = '1;
	localparam logic [IN_BITS-1:0] MOST_NEG = {1'b1, {(IN_BITS-1){1'b0}}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int                    pending;
	int                    errors;
	bit                    idle_on = 1'b1;
	int unsigned           hold_requests = 0;

	i2a_in_if  in_ch();
	i2a_out_if out_ch();

	int64_to_radix_ascii_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	i2a_digit_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_format(input logic [RADIX_BITS-1:0] rdx, input logic sgn,
		input logic [CHAR_BITS-1:0] lb);
		write_reg(REG_RADIX, CFG_DATA_W'(rdx));
		write_reg(REG_SIGNED_MODE, CFG_DATA_W'(sgn));
		write_reg(REG_LETTER_BASE, CFG_DATA_W'(lb));
	endtask

	// Keep valid high across back-to-back transfers; drop it only while idling.
	task automatic send_value(input logic [IN_BITS-1:0] v);
		if (idle_on) begin
			while ($urandom_range(99) < 32) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Hold off the input until every predicted digit has come out.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Mostly short values so long digit strings stay rare; full patterns toggle every bit.
	function automatic logic [IN_BITS-1:0] random_value();
		logic [IN_BITS-1:0] v;
		int unsigned        pick;
		int unsigned        w;
		v = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 15) begin
			return v;
		end
		w = (pick < 75) ? $urandom_range(16, 1) : $urandom_range(IN_BITS, 1);
		v = v & (ALL_ONES >> (IN_BITS - w));
		if ($urandom_range(3) == 0) begin
			v = -v;
		end
		return v;
	endfunction

	task automatic run_random(input logic [RADIX_BITS-1:0] rdx, input logic sgn,
		input logic [CHAR_BITS-1:0] lb, input int count);
		int i;
		set_format(rdx, sgn, lb);
		for (i = 0; i < count; i++) begin
			send_value(random_value());
		end
		drain();
	endtask

	initial begin : sink_side
		int          hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(idle_on && $urandom_range(99) < 32);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int i;
		in_ch.valid <= 1'b0;
		in_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset format: decimal, signed, lower-case letters
		send_value('0);
		send_value(IN_BITS'(1));
		send_value(ALL_ONES);
		send_value(MOST_NEG);
		send_value(~MOST_NEG);
		send_value(IN_BITS'(1234567890));
		drain();

		set_format(6'd36, 1'b0, 8'd65);
		send_value(ALL_ONES);
		send_value(IN_BITS'(35));
		send_value(IN_BITS'(36));
		drain();

		// letters run past 255 and wrap
		set_format(6'd36, 1'b1, 8'd255);
		send_value(-IN_BITS'(35));
		send_value(MOST_NEG);
		send_value(64'h0123_4567_89ab_cdef);
		drain();

		// longest digit string: 64 binary digits
		set_format(6'd2, 1'b0, 8'd97);
		send_value(ALL_ONES);
		send_value(MOST_NEG);
		drain();

		write_reg(REG_RADIX, 32'd37);
		send_value(IN_BITS'(10));
		drain();
		// write to an unmapped index; radix must stay out of range
		write_reg(REG_UNUSED, 32'd10);
		send_value(IN_BITS'(5));
		drain();
		write_reg(REG_RADIX, 32'd1);
		send_value(IN_BITS'(7));
		drain();

		// stall the output long enough to back up the input, then pause the sender
		set_format(6'd10, 1'b1, 8'd97);
		hold_requests++;
		for (i = 0; i < 60; i++) begin
			send_value(random_value());
		end
		drain();
		for (i = 0; i < 60; i++) begin
			send_value(random_value());
		end
		drain();

		idle_on = 1'b0;
		run_random(6'd16, 1'b0, 8'd65, 80);
		idle_on = 1'b1;
		run_random(6'd2, 1'b1, 8'd97, 30);
		run_random(6'd36, 1'b0, 8'd255, 60);
		run_random(6'd8, 1'b1, 8'd0, 50);
		run_random(6'd3, 1'b0, 8'd200, 30);
		run_random(6'd0, 1'b1, 8'd97, 25);
		run_random(6'd63, 1'b0, 8'd97, 25);
		run_random(6'd7, 1'b1, 8'd128, 60);
		run_random(6'd35, 1'b1, 8'd122, 20);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
